// ===== hdl/evad_pkg.sv =====
// Package for the energy based voice activity detector.
// Holds the word types, state encodings, register indexes and constants.
// No dependencies; every other file imports it.
package evad_pkg;

    localparam int MAX_FRAME_SAMPLES_DEF = 4096;
    localparam int RMS_W = 20;
    localparam int CFG_W = 20;
    localparam int TH_W  = 28;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               frame_end;
        logic               playback_active;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       vad_state;
        logic [RMS_W-1:0] frame_rms;
        logic             state_changed;
        logic             frame_loud;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_ROOT,
        S_CMP,
        S_DEC
    } t_state;

    typedef enum logic [1:0] {
        D_IDLE,
        D_DIV,
        D_SQRT
    } t_ds_state;

    localparam logic [1:0] VAD_SILENCE      = 2'd0;
    localparam logic [1:0] VAD_SPEAKING     = 2'd1;
    localparam logic [1:0] VAD_SIL_DETECTED = 2'd2;

    localparam logic [1:0] CFG_PROFILE_MODE  = 2'd0;
    localparam logic [1:0] CFG_NOISE_THRESH  = 2'd1;
    localparam logic [1:0] CFG_SPEECH_LEVEL  = 2'd2;
    localparam logic [1:0] CFG_SILENCE_HOLD  = 2'd3;

    localparam logic [2:0] PROF_STANDARD  = 3'd0;
    localparam logic [2:0] PROF_HEAVY     = 3'd1;
    localparam logic [2:0] PROF_ADAPTIVE  = 3'd2;
    localparam logic [2:0] PROF_SENSITIVE = 3'd3;

    localparam logic [2:0]       RST_PROFILE_MODE = 3'd0;
    localparam logic [RMS_W-1:0] RST_NOISE_THRESH = 20'd3200;
    localparam logic [RMS_W-1:0] RST_SPEECH_LEVEL = 20'd0;
    localparam logic [7:0]       RST_SILENCE_HOLD = 8'd15;

    localparam logic [TH_W-1:0] K_STD_RMS      = 28'd100;
    localparam logic [TH_W-1:0] K_STD_NOISE    = 28'd115;
    localparam logic [TH_W-1:0] K_ADAPT_FLOOR  = 28'd32000;
    localparam logic [TH_W-1:0] K_ADAPT_LEVEL  = 28'd6;
    localparam logic [TH_W-1:0] K_ADAPT_RMS    = 28'd20;
    localparam logic [TH_W-1:0] K_ADAPT_PB_RMS = 28'd40;
    localparam logic [TH_W-1:0] K_BOOST_NUM    = 28'd3;
    localparam logic [TH_W-1:0] K_BOOST_DEN    = 28'd2;
    localparam logic [TH_W-1:0] K_SENSITIVE    = 28'd2400;

endpackage

// ===== hdl/evad_divsqrt.sv =====
// Frame RMS unit: floor(sqrt(sum * 256 / count)) by restoring division and
// digit-by-digit square root, both stepping one shared subtractor.
// Depends on evad_pkg.
module evad_divsqrt #(
    parameter int CNT_W = 13,
    parameter int SUM_W = 44
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [SUM_W-1:0]          i_sum,
    input  logic [CNT_W-1:0]          i_count,
    output logic                      o_done,
    output logic [evad_pkg::RMS_W-1:0] o_root
);
    import evad_pkg::*;

    localparam int DIV_W = SUM_W + 8;
    localparam int RAD_W = 2 * RMS_W;
    localparam int ALU_W = (CNT_W + 1 > RMS_W + 3) ? CNT_W + 1 : RMS_W + 3;
    localparam int IT_W  = $clog2(DIV_W + 1);

    t_ds_state        r_state, n_state;
    logic [IT_W-1:0]  r_iter,  n_iter;
    logic [ALU_W-1:0] r_rem,   n_rem;
    logic [DIV_W-1:0] r_quo,   n_quo;
    logic [CNT_W-1:0] r_div,   n_div;
    logic [RAD_W-1:0] r_rad,   n_rad;
    logic [RMS_W-1:0] r_root,  n_root;
    logic             r_done,  n_done;

    logic [ALU_W-1:0] w_a, w_b;
    logic [ALU_W:0]   w_diff;
    logic             w_fits;
    logic [DIV_W-1:0] w_quo_next;

    assign w_diff = {1'b0, w_a} - {1'b0, w_b};
    assign w_fits = !w_diff[ALU_W];
    assign w_quo_next = {r_quo[DIV_W-2:0], w_fits};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_iter <= n_iter;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_div  <= n_div;
        r_rad  <= n_rad;
        r_root <= n_root;
    end

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_div   = r_div;
        n_rad   = r_rad;
        n_root  = r_root;
        n_done  = 1'b0;
        w_a     = '0;
        w_b     = '0;
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_quo  = {i_sum, 8'd0};
                    n_div  = i_count;
                    n_rem  = '0;
                    n_iter = IT_W'(DIV_W);
                    n_root = '0;
                    if (i_count == '0) begin
                        n_done = 1'b1;
                    end else begin
                        n_state = D_DIV;
                    end
                end
            end
            D_DIV: begin
                w_a = ALU_W'({r_rem[CNT_W-1:0], r_quo[DIV_W-1]});
                w_b = ALU_W'(r_div);
                n_rem  = w_fits ? w_diff[ALU_W-1:0] : w_a;
                n_quo  = w_quo_next;
                n_iter = r_iter - 1'b1;
                if (r_iter == IT_W'(1)) begin
                    // The quotient is a mean square times 256, below 2**39.
                    n_rad   = w_quo_next[RAD_W-1:0];
                    n_rem   = '0;
                    n_root  = '0;
                    n_iter  = IT_W'(RMS_W);
                    n_state = D_SQRT;
                end
            end
            D_SQRT: begin
                w_a = ALU_W'({r_rem[RMS_W:0], r_rad[RAD_W-1 -: 2]});
                w_b = ALU_W'({r_root, 2'b01});
                n_rem  = w_fits ? w_diff[ALU_W-1:0] : w_a;
                n_root = {r_root[RMS_W-2:0], w_fits};
                n_rad  = {r_rad[RAD_W-3:0], 2'b00};
                n_iter = r_iter - 1'b1;
                if (r_iter == IT_W'(1)) begin
                    n_done  = 1'b1;
                    n_state = D_IDLE;
                end
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hdl/energy_voice_activity_detector.sv =====
// Top level of the energy based voice activity detector.
// Accumulates sample energy, closes frames through evad_divsqrt and runs the
// hangover machine. Depends on evad_pkg and evad_divsqrt.
//
//  Channel   Direction  Handshake                 Word
//  in        input      i_in_valid / o_in_ready   t_in_word
//  out       output     o_out_valid / i_out_ready t_out_word
//  cfg       input      i_cfg_we                  i_cfg_addr, i_cfg_data
//
// A sample without frame end is accepted, then squared and added before the next is taken.
// A frame end sample is closed by the one-bit-per-cycle divide and
// two-bit-per-cycle root, which share one subtractor. Reset is
// synchronous and restores the register defaults.
// A result waits in the output register while the next frame accumulates;
// a new frame end stalls only if that register is still full.
module energy_voice_activity_detector #(
    parameter int MAX_FRAME_SAMPLES = evad_pkg::MAX_FRAME_SAMPLES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  evad_pkg::t_in_word          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output evad_pkg::t_out_word         o_out_data,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_addr,
    input  logic [evad_pkg::CFG_W-1:0]  i_cfg_data
);
    import evad_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int SUM_W = 31 + CNT_W;

    t_state           r_state, n_state;
    t_in_word         r_in;
    logic [SUM_W-1:0] r_sum,   n_sum;
    logic [CNT_W-1:0] r_count, n_count;
    logic [RMS_W-1:0] r_rms,   n_rms;
    logic [TH_W-1:0]  r_lhs,   n_lhs;
    logic [TH_W-1:0]  r_rhs,   n_rhs;
    logic             r_speaking, n_speaking;
    logic [7:0]       r_quiet,    n_quiet;
    logic [1:0]       r_vad,      n_vad;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out,       n_out;

    logic [2:0]       r_profile;
    logic [RMS_W-1:0] r_noise;
    logic [RMS_W-1:0] r_level;
    logic [7:0]       r_hold;

    logic [15:0]      w_mag;
    logic [31:0]      w_sq;
    logic [SUM_W-1:0] w_sum_acc;
    logic [CNT_W-1:0] w_cnt_acc;
    logic             w_ds_start;
    logic             w_ds_done;
    logic [RMS_W-1:0] w_ds_root;
    logic [TH_W-1:0]  w_rms_x, w_noise_x, w_level6, w_base;
    logic             w_loud, w_changed;
    logic [7:0]       w_quiet_inc;
    logic             w_accept;

    assign w_accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    assign w_mag = r_in.sample[15] ? (16'(~r_in.sample) + 16'd1) : 16'(r_in.sample);
    assign w_sq  = w_mag * w_mag;
    always_comb begin
        w_sum_acc = r_sum;
        w_cnt_acc = r_count;
        if (r_count < CNT_W'(MAX_FRAME_SAMPLES)) begin
            w_sum_acc = r_sum + SUM_W'(w_sq);
            w_cnt_acc = r_count + 1'b1;
        end
    end

    assign w_ds_start = (r_state == S_ACC) && r_in.frame_end;

    evad_divsqrt #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ds_start),
        .i_sum   (w_sum_acc),
        .i_count (w_cnt_acc),
        .o_done  (w_ds_done),
        .o_root  (w_ds_root)
    );

    assign w_rms_x   = TH_W'(r_rms);
    assign w_noise_x = TH_W'(r_noise);
    assign w_level6  = TH_W'(r_level) * K_ADAPT_LEVEL;
    assign w_base    = (w_level6 < K_ADAPT_FLOOR) ? K_ADAPT_FLOOR : w_level6;
    assign w_loud    = r_lhs > r_rhs;
    assign w_quiet_inc = r_quiet + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_count     <= '0;
            r_speaking  <= 1'b0;
            r_quiet     <= '0;
            r_vad       <= VAD_SILENCE;
            r_out_valid <= 1'b0;
            r_profile   <= RST_PROFILE_MODE;
            r_noise     <= RST_NOISE_THRESH;
            r_level     <= RST_SPEECH_LEVEL;
            r_hold      <= RST_SILENCE_HOLD;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_speaking  <= n_speaking;
            r_quiet     <= n_quiet;
            r_vad       <= n_vad;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PROFILE_MODE: r_profile <= i_cfg_data[2:0];
                    CFG_NOISE_THRESH: r_noise   <= i_cfg_data;
                    CFG_SPEECH_LEVEL: r_level   <= i_cfg_data;
                    CFG_SILENCE_HOLD: r_hold    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        if (w_accept) begin
            r_in <= i_in_data;
        end
        r_rms <= n_rms;
        r_lhs <= n_lhs;
        r_rhs <= n_rhs;
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_count     = r_count;
        n_rms       = r_rms;
        n_lhs       = r_lhs;
        n_rhs       = r_rhs;
        n_speaking  = r_speaking;
        n_quiet     = r_quiet;
        n_vad       = r_vad;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_changed   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (r_in.frame_end) begin
                    n_sum   = '0;
                    n_count = '0;
                    n_state = S_ROOT;
                end else begin
                    n_sum   = w_sum_acc;
                    n_count = w_cnt_acc;
                    n_state = S_IDLE;
                end
            end
            S_ROOT: begin
                if (w_ds_done) begin
                    n_rms   = w_ds_root;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_lhs = w_rms_x;
                n_rhs = w_noise_x;
                case (r_profile)
                    PROF_STANDARD: begin
                        n_lhs = w_rms_x * K_STD_RMS;
                        n_rhs = w_noise_x * K_STD_NOISE;
                    end
                    PROF_HEAVY: begin
                        if (r_in.playback_active) begin
                            n_lhs = w_rms_x * K_BOOST_DEN;
                            n_rhs = w_noise_x * K_BOOST_NUM;
                        end
                    end
                    PROF_ADAPTIVE: begin
                        if (r_in.playback_active) begin
                            n_lhs = w_rms_x * K_ADAPT_PB_RMS;
                            n_rhs = w_base * K_BOOST_NUM;
                        end else begin
                            n_lhs = w_rms_x * K_ADAPT_RMS;
                            n_rhs = w_base;
                        end
                    end
                    PROF_SENSITIVE: begin
                        n_rhs = K_SENSITIVE;
                    end
                    default: ;
                endcase
                n_state = S_DEC;
            end
            S_DEC: begin
                if (!r_out_valid || i_out_ready) begin
                    if (w_loud) begin
                        if (!r_speaking) begin
                            n_speaking = 1'b1;
                            n_vad      = VAD_SPEAKING;
                            w_changed  = 1'b1;
                        end
                        n_quiet = '0;
                    end else if (r_speaking) begin
                        n_quiet = w_quiet_inc;
                        if (w_quiet_inc >= r_hold) begin
                            n_speaking = 1'b0;
                            n_quiet    = '0;
                            n_vad      = VAD_SIL_DETECTED;
                            w_changed  = 1'b1;
                        end
                    end
                    if (n_vad == VAD_SIL_DETECTED && !w_changed) begin
                        n_vad = VAD_SILENCE;
                    end
                    n_out.vad_state     = n_vad;
                    n_out.frame_rms     = r_rms;
                    n_out.state_changed = w_changed;
                    n_out.frame_loud    = w_loud;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A reported change is always a start of speech or a declared silence.
    a_change_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.state_changed) |->
        (o_out_data.vad_state == VAD_SPEAKING || o_out_data.vad_state == VAD_SIL_DETECTED))
        else $error("state change reported with a silence code");

    // The silence-detected code lasts for exactly the frame that declared it.
    a_sil_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.vad_state == VAD_SIL_DETECTED) |->
        o_out_data.state_changed)
        else $error("silence detected without a state change");

    // The quiet frame count only runs while speaking.
    a_quiet_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_speaking |-> (r_quiet == '0))
        else $error("quiet frame count set while not speaking");

    // The sample count never passes the frame limit.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_FRAME_SAMPLES))
        else $error("sample count beyond frame limit");

    // The accumulators are clear while a frame is being closed.
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) |-> (r_count == '0 && r_sum == '0))
        else $error("accumulators not cleared at frame end");

endmodule
